/* sv/two_page_video_display_generator_assert.svh */
// Assertion helpers for the two-page video generator.
// The enclosing module supplies aclk and aresetn.
`ifndef TWO_PAGE_VIDEO_DISPLAY_GENERATOR_ASSERT_SVH
`define TWO_PAGE_VIDEO_DISPLAY_GENERATOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define TPVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tpvd assertion failed");

// Next-cycle implication, held off during reset.
`define TPVD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tpvd assertion failed");

`endif

/* sv/tpvd_pkg.sv */
package tpvd_pkg;

    localparam int GLYPH_BYTES    = 512;
    localparam int GLYPH_AW       = $clog2(GLYPH_BYTES);
    localparam int LINES_PER_PAGE = 128;
    localparam int LINE_W         = $clog2(LINES_PER_PAGE);
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VDU_OPTIONS = 1'b1;

    localparam logic [7:0] PAGE_SELECT_RST = 8'h12;
    localparam logic [6:0] VDU_OPTIONS_RST = 7'h05;

    localparam logic [4:0] COUNT_CHAR = 5'd8;
    localparam logic [4:0] COUNT_GFX  = 5'd16;

    typedef enum logic {
        ACT_GLYPH_LOAD = 1'b0,
        ACT_VIDEO      = 1'b1
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [8:0]  glyph_index;
        logic [7:0]  glyph_byte;
        logic [7:0]  video_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] pixels;
        logic [4:0]  pixel_count;
        logic [7:0]  screen_line;
        logic [6:0]  first_x;
        logic [11:0] video_address;
        logic        frame_end;
    } out_t;

    // Classified beat handed from front to back.
    typedef struct packed {
        logic                is_load;
        logic [GLYPH_AW-1:0] mem_addr;
        logic [7:0]          data;
        logic                gfx;
        logic                inv;
        logic [7:0]          screen_line;
        logic [6:0]          first_x;
        logic [11:0]         video_address;
        logic                frame_end;
    } qent_t;

endpackage

/* sv/tpvd_front.sv */
module tpvd_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tpvd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpvd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tpvd_pkg::in_t                    s_data,
    input  logic                             q_full,
    output logic                             q_push,
    output tpvd_pkg::qent_t                  q_data
);
    import tpvd_pkg::*;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_PAGE - 1);
    localparam logic [3:0] COL_LAST_CHAR = 4'd15;
    localparam logic [3:0] COL_LAST_GFX  = 4'd7;

    logic [7:0]        page_select_reg;
    logic [6:0]        vdu_options_reg;
    logic              page_reg, page_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [3:0]        col_reg, col_next;

    logic       top, inv, gfx, line_end, video_beat;
    logic [3:0] base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_select_reg <= PAGE_SELECT_RST;
            vdu_options_reg <= VDU_OPTIONS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PAGE_SELECT: page_select_reg <= cfg_data;
                REG_VDU_OPTIONS: vdu_options_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign s_ready    = !q_full;
    assign q_push     = s_valid && s_ready;
    assign video_beat = q_push && (s_data.action == ACT_VIDEO);

    always_comb begin
        top  = vdu_options_reg[0] ? page_reg : !page_reg;
        base = page_select_reg[3:0] | (top ? page_select_reg[7:4] : 4'd0);
        inv  = vdu_options_reg[6] ? !top : !vdu_options_reg[2];
        gfx  = vdu_options_reg[5] ? top : vdu_options_reg[1];
        line_end = gfx ? (col_reg >= COL_LAST_GFX) : (col_reg == COL_LAST_CHAR);

        q_data.is_load     = (s_data.action == ACT_GLYPH_LOAD);
        q_data.gfx         = gfx;
        q_data.inv         = inv;
        q_data.screen_line = {page_reg, line_reg};
        q_data.frame_end   = line_end && page_reg && (line_reg == LAST_LINE);
        if (s_data.action == ACT_GLYPH_LOAD) begin
            q_data.mem_addr = s_data.glyph_index;
            q_data.data     = s_data.glyph_byte;
        end else begin
            // font row: code * 8 + line within the character cell
            q_data.mem_addr = {s_data.video_byte[5:0], line_reg[2:0]};
            q_data.data     = s_data.video_byte;
        end
        if (gfx) begin
            q_data.video_address = {base, line_reg[6:2], col_reg[2:0]};
            q_data.first_x       = {col_reg[2:0], 4'd0};
        end else begin
            q_data.video_address = {base, line_reg[6:3], col_reg};
            q_data.first_x       = {col_reg, 3'd0};
        end

        page_next = page_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (video_beat) begin
            if (line_end) begin
                col_next = 4'd0;
                if (line_reg == LAST_LINE) begin
                    line_next = '0;
                    page_next = !page_reg;
                end else begin
                    line_next = line_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg <= 1'b0;
            line_reg <= '0;
            col_reg  <= 4'd0;
        end else begin
            page_reg <= page_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

/* sv/tpvd_queue.sv */
module tpvd_queue #(
    parameter int DEPTH = tpvd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tpvd_pkg::qent_t push_data,
    output logic            full,
    input  logic            pop,
    output tpvd_pkg::qent_t pop_data,
    output logic            empty
);
    import tpvd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    qent_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/tpvd_back.sv */
module tpvd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  tpvd_pkg::qent_t q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output tpvd_pkg::out_t  m_data
);
    import tpvd_pkg::*;

    logic [7:0] glyph_mem [GLYPH_BYTES];

    logic       s1_valid_reg, s1_valid_next;
    qent_t      s1_meta_reg;
    logic [7:0] glyph_rd_reg;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg;

    logic  out_free, s1_free, s1_adv, pop_video, pop_load;
    out_t  result;
    logic [15:0] dbl;

    assign out_free  = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || out_free;
    // loads only touch the glyph store, so they never wait on the output
    assign q_pop     = !q_empty && (q_data.is_load || s1_free);
    assign pop_load  = q_pop && q_data.is_load;
    assign pop_video = q_pop && !q_data.is_load;

    always_ff @(posedge aclk) begin
        if (pop_load) begin
            glyph_mem[q_data.mem_addr] <= q_data.data;
        end
        if (pop_video) begin
            glyph_rd_reg <= glyph_mem[q_data.mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_video) begin
            s1_meta_reg <= q_data;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            dbl[2*i +: 2] = {2{s1_meta_reg.data[i]}};
        end
        result.screen_line   = s1_meta_reg.screen_line;
        result.first_x       = s1_meta_reg.first_x;
        result.video_address = s1_meta_reg.video_address;
        result.frame_end     = s1_meta_reg.frame_end;
        if (s1_meta_reg.gfx) begin
            result.pixels      = dbl ^ {16{s1_meta_reg.inv}};
            result.pixel_count = COUNT_GFX;
        end else begin
            result.pixels      = {8'd0, {glyph_rd_reg[6:0], 1'b0}
                                 ^ {8{s1_meta_reg.inv ^ s1_meta_reg.data[7]}}};
            result.pixel_count = COUNT_CHAR;
        end

        s1_valid_next = pop_video ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/two_page_video_display_generator.sv */
// Raster generator for two stacked 128-line pages.
// Input channel (s_valid/s_ready/s_data): each beat is either a glyph store
// load (one font row byte) or one video RAM byte in raster order.
// Output channel (m_valid/m_ready/m_data): one beat per video byte with the
// pixels, pixel count, screen line, first x, video address and frame end.
// Glyph loads produce no output beat.
// Config port: cfg_wr_en writes cfg_data into register cfg_index
// (0 page_select, 1 vdu_options) at the clock edge; write only when idle.
// A video byte is registered in the queue, the read stage and the output register.
// Throughput: one beat per cycle while m_ready stays high, set by the single glyph store port and
// the one-entry read stage in the back end.
// A small queue separates the front (position counters, mode decode) from
// the back (glyph store, pixel formation, output register).
// Reset: position returns to page 0 line 0 column 0, registers take their
// defaults; the glyph store keeps whatever it held and must be loaded.
// When m_ready is low the output holds, the queue fills, and s_ready drops
// once the queue is full; no beat is lost.
module two_page_video_display_generator #(
    parameter int QUEUE_DEPTH = tpvd_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tpvd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpvd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tpvd_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tpvd_pkg::out_t                   m_data
);
    import tpvd_pkg::*;

    `include "two_page_video_display_generator_assert.svh"

    logic  q_full, q_empty, q_push, q_pop;
    qent_t q_in, q_out;

    tpvd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tpvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    tpvd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // frame end only on the last line of the second page
    `TPVD_ASSERT_IMP(a_frame_end_line, m_valid && m_data.frame_end, m_data.screen_line == 8'd255)
    // character beats leave the upper byte clear
    `TPVD_ASSERT_IMP(a_char_upper_zero, m_valid && m_data.pixel_count == COUNT_CHAR, m_data.pixels[15:8] == 8'd0)
    // queue push while full would drop a beat
    `TPVD_ASSERT_NXT(a_queue_fill, q_full && !q_pop, !q_push)

endmodule

/* test/tb_two_page_video_display_generator.sv */
module tb_two_page_video_display_generator;
    import tpvd_pkg::*;

    class raster_scoreboard;
        logic [7:0] font [GLYPH_BYTES];
        bit         font_written [GLYPH_BYTES];
        logic [7:0] page_select;
        logic [6:0] vdu_options;
        bit         page;
        logic [6:0] line;
        logic [3:0] column;
        out_t       pixel_q[$];
        int         errors;
        int         videos;
        int         loads;
        int         frames;
        int         gfx_beats;
        int         page1_beats;

        function new();
            page_select = PAGE_SELECT_RST;
            vdu_options = VDU_OPTIONS_RST;
            page        = 1'b0;
            line        = '0;
            column      = '0;
            errors      = 0;
            videos      = 0;
            loads       = 0;
            frames      = 0;
            gfx_beats   = 0;
            page1_beats = 0;
            foreach (font_written[i]) font_written[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == REG_PAGE_SELECT) begin
                page_select = val;
            end else begin
                vdu_options = val[6:0];
            end
        endfunction

        // bit0 set: the second page is the top one
        function bit is_top();
            return vdu_options[0] ? page : !page;
        endfunction

        function bit is_gfx();
            return vdu_options[5] ? is_top() : vdu_options[1];
        endfunction

        function bit is_inv();
            return vdu_options[6] ? !is_top() : !vdu_options[2];
        endfunction

        // True when a video byte at the current position would read an unloaded font row
        function bit needs_font(logic [7:0] vb);
            return !is_gfx() && !font_written[{vb[5:0], line[2:0]}];
        endfunction

        function void note_beat(in_t d);
            out_t       e;
            logic [11:0] base;
            logic [7:0] g;
            logic [2:0] c;
            bit         last;
            if (d.action == ACT_GLYPH_LOAD) begin
                font[d.glyph_index]         = d.glyph_byte;
                font_written[d.glyph_index] = 1'b1;
                loads++;
                return;
            end
            base          = {page_select[3:0] | (is_top() ? page_select[7:4] : 4'h0), 8'h00};
            e.screen_line = {page, line};
            if (is_gfx()) begin
                c               = column[2:0];
                e.video_address = base + {line[6:2], c};
                for (int i = 0; i < 8; i++) e.pixels[2*i +: 2] = {2{d.video_byte[i]}};
                if (is_inv()) e.pixels = ~e.pixels;
                e.pixel_count = COUNT_GFX;
                e.first_x     = {c, 4'b0000};
                last          = column >= 4'd7;
                gfx_beats++;
            end else begin
                g               = font[{d.video_byte[5:0], line[2:0]}];
                e.video_address = base + {line[6:3], column};
                e.pixels        = {8'h00, g[6:0], 1'b0};
                if (is_inv() ^ d.video_byte[7]) e.pixels ^= 16'h00ff;
                e.pixel_count = COUNT_CHAR;
                e.first_x     = {column, 3'b000};
                last          = column == 4'd15;
            end
            e.frame_end = last && page && (line == 7'd127);
            if (e.frame_end) frames++;
            if (page) page1_beats++;
            if (last) begin
                column = '0;
                if (line == 7'd127) page = !page;
                line = line + 7'd1;
            end else begin
                column = column + 4'd1;
            end
            videos++;
            pixel_q.push_back(e);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(out_t got);
            out_t e;
            if (pixel_q.size() == 0) begin
                $error("result beat with nothing expected: 0x%0h", got);
                errors++;
                return;
            end
            e = pixel_q.pop_front();
            check_field("pixels", e.pixels, got.pixels);
            check_field("pixel_count", 16'(e.pixel_count), 16'(got.pixel_count));
            check_field("screen_line", 16'(e.screen_line), 16'(got.screen_line));
            check_field("first_x", 16'(e.first_x), 16'(got.first_x));
            check_field("video_address", 16'(e.video_address), 16'(got.video_address));
            check_field("frame_end", 16'(e.frame_end), 16'(got.frame_end));
        endfunction
    endclass

    localparam logic [7:0] DIR_CHAR [12] = '{8'h00, 8'h80, 8'h3f, 8'hff, 8'h01, 8'h41,
                                             8'hc1, 8'h3f, 8'h00, 8'h01, 8'h80, 8'h3f};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;

    raster_scoreboard sb = new();
    bit sender_calm;
    int settings;

    two_page_video_display_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_beat(in_t d);
        int n;
        @(negedge aclk);
        s_data  <= d;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(d);
        n = sender_calm ? 0 : pick_gap();
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic stop_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_glyph(logic [8:0] idx, logic [7:0] val);
        in_t d;
        d.action      = ACT_GLYPH_LOAD;
        d.glyph_index = idx;
        d.glyph_byte  = val;
        d.video_byte  = 8'($urandom_range(0, 255));
        push_beat(d);
    endtask

    task automatic send_video(logic [7:0] vb);
        in_t d;
        // never let the block read a font row that was not loaded
        if (sb.needs_font(vb)) send_glyph({vb[5:0], sb.line[2:0]}, 8'($urandom_range(0, 255)));
        d.action      = ACT_VIDEO;
        d.glyph_index = 9'($urandom_range(0, 511));
        d.glyph_byte  = 8'($urandom_range(0, 255));
        d.video_byte  = vb;
        push_beat(d);
    endtask

    // loads leave no result beat, so allow for the pipeline after the queue empties
    task automatic drain();
        while (sb.pixel_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_mode(logic [7:0] psel, logic [6:0] opts);
        stop_sender();
        drain();
        write_reg(REG_PAGE_SELECT, psel);
        write_reg(REG_VDU_OPTIONS, {1'b0, opts});
        settings++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_beat(m_data);
    end

    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(negedge aclk);
        end
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int         start;
        int         len;
        logic [7:0] psel;
        logic [6:0] opts;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        sender_calm = 1'b0;
        settings    = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: character mode, normal video on the first page
        send_glyph(9'd0, 8'hff);
        send_glyph(9'd511, 8'h00);
        send_glyph(9'd504, 8'h80);
        send_glyph(9'd8, 8'h2a);
        foreach (DIR_CHAR[i]) send_video(DIR_CHAR[i]);
        // switch to graphics in mid-line: column past 7 ends the line at once
        set_mode(8'h12, 7'h02);
        send_video(8'hff);
        send_video(8'h00);
        send_video(8'ha5);
        // mixed mode and mixed invert, all page bits set
        set_mode(8'hff, 7'h7f);
        send_video(8'h00);
        send_video(8'h80);
        set_mode(8'h00, 7'h00);
        send_video(8'h7f);

        start = sb.videos + sb.loads;
        while (sb.videos + sb.loads - start < 900) begin
            case ($urandom_range(0, 9))
                0:       psel = 8'h00;
                1:       psel = 8'hff;
                default: psel = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0:       opts = 7'h00;
                1:       opts = 7'h7f;
                default: opts = 7'($urandom_range(0, 127));
            endcase
            set_mode(psel, opts);
            sender_calm = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 60);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_glyph(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
                end else begin
                    send_video(8'($urandom_range(0, 255)));
                end
                // hold off until the output side has caught up
                if ($urandom_range(0, 299) == 0) begin
                    stop_sender();
                    drain();
                end
            end
        end

        stop_sender();
        drain();
        repeat (20) @(posedge aclk);
        if (sb.pixel_q.size() != 0) begin
            $error("%0d expected result beats never arrived", sb.pixel_q.size());
            sb.errors++;
        end
        $display("Run covered %0d video beats (%0d graphics, %0d on the second page), %0d glyph loads",
                 sb.videos, sb.gfx_beats, sb.page1_beats, sb.loads);
        $display("across %0d register settings and %0d complete frames", settings, sb.frames);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
